@@ rtl/core/rarp_pkg.sv @@
// rarp_pkg: shared types and constants for the RESP array request parser
// holds the request and response payload structs, character codes and field widths
// no dependencies

package rarp_pkg;

   // widths of the announced parameter count and bulk string length
   localparam int COUNT_BITS  = 16;
   localparam int LENGTH_BITS = 20;
   localparam int INDEX_BITS  = 16;

   // framing characters
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   // one request byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic       clear;
   } req_type;

   // one parser result
   typedef struct packed {
      logic                  payload_valid;
      logic [7:0]            payload_byte;
      logic [INDEX_BITS-1:0] param_index;
      logic                  param_last;
      logic                  command_done;
      logic                  error;
   } rsp_type;

   // parser phases, one-hot
   typedef enum logic [9:0] {
      ST_STAR     = 10'b00_0000_0001,
      ST_COUNT    = 10'b00_0000_0010,
      ST_COUNT_LF = 10'b00_0000_0100,
      ST_DOLLAR   = 10'b00_0000_1000,
      ST_LEN      = 10'b00_0001_0000,
      ST_LEN_LF   = 10'b00_0010_0000,
      ST_DATA     = 10'b00_0100_0000,
      ST_DATA_CR  = 10'b00_1000_0000,
      ST_DATA_LF  = 10'b01_0000_0000,
      ST_FAULT    = 10'b10_0000_0000
   } state_type;

endpackage

@@ rtl/core/resp_array_request_parser.sv @@
// resp_array_request_parser: byte-serial RESP array-of-bulk-strings request parser
// depends on rarp_pkg for payload structs, phase encoding and widths
//
// Usage:
//   req channel: one request byte per transfer (data_byte, clear). clear drops the
//   byte and returns the parser to waiting for '*' with all counters zeroed.
//   rsp channel: exactly one result per request byte: payload byte with its
//   parameter index and last mark, a done mark on the LF closing the last
//   parameter, and a sticky error flag that holds until a clear byte.
//   Path: a byte accepted on req passes one input register, then all parsing
//   logic, then one result register that drives rsp.
//   Throughput: one byte per cycle sustained while rsp_ready is high; the parser
//   phase and counters update as a byte moves from the input register into the
//   result register. Reset (synchronous, active high) empties both registers and
//   sets the parser to waiting for '*' with counters zeroed.
//   When rsp_ready is low the result register holds, the input register still
//   takes one more byte, and req_ready drops only once both are full.

module resp_array_request_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rarp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rarp_pkg::rsp_type rsp_data
);

   localparam int CB = rarp_pkg::COUNT_BITS;
   localparam int LB = rarp_pkg::LENGTH_BITS;

   // pipeline registers
   logic              in_valid_ff, in_valid_in;
   rarp_pkg::req_type in_data_ff;
   logic              out_valid_ff, out_valid_in;
   rarp_pkg::rsp_type out_data_ff, out_data_in;
   logic              adv_out;
   logic              adv_in;

   // parser state
   rarp_pkg::state_type state_ff, state_in;
   logic [CB-1:0]       total_ff, total_in;
   logic [CB-1:0]       count_ff, count_in;
   logic [LB-1:0]       length_ff, length_in;
   logic [LB-1:0]       left_ff, left_in;

   // per-byte decode
   logic [7:0]    cur_byte;
   logic          is_digit;
   logic [3:0]    digit;
   logic [CB+3:0] total_next;
   logic [LB+3:0] length_next;
   logic          total_over;
   logic          length_over;
   logic [CB-1:0] count_inc;
   logic          fault;

   // handshake
   assign adv_out   = !out_valid_ff || rsp_ready;
   assign adv_in    = in_valid_ff && adv_out;
   assign req_ready = !in_valid_ff || adv_out;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign in_valid_in  = (req_valid && req_ready) ? 1'b1 : (adv_in ? 1'b0 : in_valid_ff);
   assign out_valid_in = adv_out ? in_valid_ff : out_valid_ff;

   // decimal accumulate: acc * 10 + digit, overflow when the top bits are set
   assign cur_byte    = in_data_ff.data_byte;
   assign is_digit    = (cur_byte >= rarp_pkg::CH_ZERO) && (cur_byte <= rarp_pkg::CH_NINE);
   assign digit       = 4'(cur_byte - rarp_pkg::CH_ZERO);
   assign total_next  = ({4'b0, total_ff} << 3) + ({4'b0, total_ff} << 1)
                        + (CB+4)'(digit);
   assign length_next = ({4'b0, length_ff} << 3) + ({4'b0, length_ff} << 1)
                        + (LB+4)'(digit);
   assign total_over  = |total_next[CB+3:CB];
   assign length_over = |length_next[LB+3:LB];
   assign count_inc   = count_ff + CB'(1);

   // parser next state and result
   always_comb begin
      state_in    = state_ff;
      total_in    = total_ff;
      count_in    = count_ff;
      length_in   = length_ff;
      left_in     = left_ff;
      out_data_in = '0;
      fault       = 1'b0;
      priority if (in_data_ff.clear) begin
         state_in  = rarp_pkg::ST_STAR;
         total_in  = '0;
         count_in  = '0;
         length_in = '0;
         left_in   = '0;
      end else begin
         unique case (state_ff)
            rarp_pkg::ST_STAR: begin
               if (cur_byte == rarp_pkg::CH_STAR) begin
                  total_in = '0;
                  count_in = '0;
                  state_in = rarp_pkg::ST_COUNT;
               end else begin
                  fault = 1'b1;
               end
            end
            rarp_pkg::ST_COUNT: begin
               if (cur_byte == rarp_pkg::CH_CR) begin
                  if (total_ff == '0) fault = 1'b1;
                  else state_in = rarp_pkg::ST_COUNT_LF;
               end else if (!is_digit || total_over) begin
                  fault = 1'b1;
               end else begin
                  total_in = total_next[CB-1:0];
               end
            end
            rarp_pkg::ST_COUNT_LF: begin
               if (cur_byte == rarp_pkg::CH_LF) state_in = rarp_pkg::ST_DOLLAR;
               else fault = 1'b1;
            end
            rarp_pkg::ST_DOLLAR: begin
               if (cur_byte == rarp_pkg::CH_DOLLAR) begin
                  length_in = '0;
                  state_in  = rarp_pkg::ST_LEN;
               end else begin
                  fault = 1'b1;
               end
            end
            rarp_pkg::ST_LEN: begin
               if (cur_byte == rarp_pkg::CH_CR) begin
                  if (length_ff == '0) fault = 1'b1;
                  else state_in = rarp_pkg::ST_LEN_LF;
               end else if (!is_digit || length_over) begin
                  fault = 1'b1;
               end else begin
                  length_in = length_next[LB-1:0];
               end
            end
            rarp_pkg::ST_LEN_LF: begin
               if (cur_byte == rarp_pkg::CH_LF) begin
                  left_in  = length_ff;
                  state_in = rarp_pkg::ST_DATA;
               end else begin
                  fault = 1'b1;
               end
            end
            rarp_pkg::ST_DATA: begin
               out_data_in.payload_valid = 1'b1;
               out_data_in.payload_byte  = cur_byte;
               out_data_in.param_index   = rarp_pkg::INDEX_BITS'(count_ff);
               if (left_ff <= LB'(1)) begin
                  out_data_in.param_last = 1'b1;
                  left_in                = '0;
                  state_in               = rarp_pkg::ST_DATA_CR;
               end else begin
                  left_in = left_ff - LB'(1);
               end
            end
            rarp_pkg::ST_DATA_CR: begin
               if (cur_byte == rarp_pkg::CH_CR) state_in = rarp_pkg::ST_DATA_LF;
               else fault = 1'b1;
            end
            rarp_pkg::ST_DATA_LF: begin
               if (cur_byte == rarp_pkg::CH_LF) begin
                  count_in = count_inc;
                  if (count_inc >= total_ff) begin
                     out_data_in.command_done = 1'b1;
                     state_in                 = rarp_pkg::ST_STAR;
                  end else begin
                     state_in = rarp_pkg::ST_DOLLAR;
                  end
               end else begin
                  fault = 1'b1;
               end
            end
            default: begin
               fault = 1'b1;
            end
         endcase
         if (fault) begin
            state_in          = rarp_pkg::ST_FAULT;
            out_data_in.error = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= rarp_pkg::ST_STAR;
         total_ff     <= '0;
         count_ff     <= '0;
         length_ff    <= '0;
         left_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (adv_in) begin
            state_ff  <= state_in;
            total_ff  <= total_in;
            count_ff  <= count_in;
            length_ff <= length_in;
            left_ff   <= left_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (adv_in) begin
         out_data_ff <= out_data_in;
      end
   end

   // a payload byte never carries done or error
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.payload_valid |-> !rsp_data.command_done && !rsp_data.error)
      else $error("payload byte flagged done or error");

   // last mark only on payload bytes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.param_last |-> rsp_data.payload_valid)
      else $error("param_last without payload");

   // an error result leaves the parser in the fault phase
   assert property (@(posedge clock) disable iff (reset)
      adv_in && out_data_in.error |=> state_ff == rarp_pkg::ST_FAULT)
      else $error("error result without fault phase");

   // a held input byte stays put while the result side stalls
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !adv_out |=> in_valid_ff && $stable(in_data_ff))
      else $error("input register lost a byte under stall");

endmodule
